// ===== hw/rtl/sqfps_pkg.sv =====
// ----------------------------------------------------------------------------
// sqfps_pkg
// shared constants and types for the square root fraction pattern search
// ----------------------------------------------------------------------------
package sqfps_pkg;

  // fraction bits of the root and longest usable pattern
  localparam int FRAC_BITS   = 128;
  localparam int PATTERN_MAX = 20;

  // fixed field widths
  localparam int RAD_W   = 20;
  localparam int PAT_W   = 20;
  localparam int LEN_W   = 5;
  localparam int POS_W   = 7;

  // integer root bits: one per radicand bit pair
  localparam int INT_PAIRS = RAD_W / 2;

  // derived datapath widths
  localparam int ROOT_W = INT_PAIRS + FRAC_BITS;
  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W);
  localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
  localparam int NS_W   = $clog2(FRAC_BITS + 1);

  // sequencer controls shared by the datapath units
  typedef struct packed {
    logic init;   // load a new transaction
    logic step;   // resolve one root bit
    logic frac;   // the bit being resolved is a fraction bit
  } seq_ctl_t;

  // search outcome
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } match_res_t;

endpackage

// ===== hw/rtl/sqfps_root_unit.sv =====
// ----------------------------------------------------------------------------
// sqfps_root_unit
// restoring square root, one root bit per step through one shared subtractor
// ----------------------------------------------------------------------------
module sqfps_root_unit
  import sqfps_pkg::*;
(
  input  logic     clk,
  input  seq_ctl_t ctl,
  input  logic [1:0] pair,
  output logic     root_bit
);

  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;

  always_comb begin
    rem_sh    = {rem[REM_W-3:0], pair};
    trial     = REM_W'({root, 2'b01});
    root_bit  = (rem_sh >= trial);
    rem_next  = root_bit ? (rem_sh - trial) : rem_sh;
    root_next = {root[ROOT_W-2:0], root_bit};
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      rem  <= '0;
      root <= '0;
    end else if (ctl.step) begin
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

// ===== hw/rtl/sqfps_match.sv =====
// ----------------------------------------------------------------------------
// sqfps_match
// sliding window over the fraction bits, keeps the first pattern hit
// ----------------------------------------------------------------------------
module sqfps_match
  import sqfps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  seq_ctl_t         ctl,
  input  logic             frac_bit,
  input  logic [PAT_W-1:0] pattern_bits,
  input  logic [LEN_W-1:0] pattern_length,
  output match_res_t       res
);

  localparam int LEXT_W = LEN_W + PLEN_W;

  logic [PATTERN_MAX-1:0] win;
  logic [PATTERN_MAX-1:0] pat_al;
  logic [PATTERN_MAX-1:0] mask_al;
  logic [PLEN_W-1:0]      len_sat;
  logic [NS_W-1:0]        nseen;
  logic                   hit;
  logic [POS_W-1:0]       pos;

  logic [LEXT_W-1:0]            len_ext;
  logic [PLEN_W-1:0]            len_in;
  logic [PLEN_W-1:0]            shamt;
  logic [PATTERN_MAX+PAT_W-1:0] pat_wide;
  logic [PATTERN_MAX-1:0]       pat_in;
  logic [PATTERN_MAX-1:0]       mask_in;
  logic [PATTERN_MAX-1:0]       win_next;
  logic [NS_W-1:0]              nseen_next;
  logic [NS_W-1:0]              diff;
  logic [NS_W+POS_W-1:0]        diff_ext;
  logic                         match_now;

  always_comb begin
    // saturate the length and align pattern and mask to the window top
    len_ext  = LEXT_W'(pattern_length);
    len_in   = (len_ext > LEXT_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : len_ext[PLEN_W-1:0];
    shamt    = PLEN_W'(PATTERN_MAX) - len_in;
    pat_wide = {{PATTERN_MAX{1'b0}}, pattern_bits};
    pat_in   = pat_wide[PATTERN_MAX-1:0];
    mask_in  = ~({PATTERN_MAX{1'b1}} >> len_in);

    // newest fraction bit enters at the top
    win_next   = (win >> 1) | (PATTERN_MAX'(frac_bit) << (PATTERN_MAX - 1));
    nseen_next = nseen + NS_W'(1);
    match_now  = !hit && (nseen_next >= NS_W'(len_sat)) &&
                 ((win_next & mask_al) == pat_al);
    diff       = nseen_next - NS_W'(len_sat);
    diff_ext   = {{POS_W{1'b0}}, diff};
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      pat_al  <= (pat_in << shamt) & mask_in;
      mask_al <= mask_in;
      len_sat <= len_in;
      win     <= '0;
    end else if (ctl.step && ctl.frac) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit   <= 1'b0;
      nseen <= '0;
      pos   <= '0;
    end else if (ctl.init) begin
      // empty pattern matches at the first offset
      hit   <= (len_in == '0);
      nseen <= '0;
      pos   <= '0;
    end else if (ctl.step && ctl.frac) begin
      nseen <= nseen_next;
      if (match_now) begin
        hit <= 1'b1;
        pos <= diff_ext[POS_W-1:0];
      end
    end
  end

  assign res.found    = hit;
  assign res.position = hit ? pos : '0;

endmodule

// ===== hw/rtl/sqrt_fraction_bit_pattern_search_top.sv =====
// ----------------------------------------------------------------------------
// sqrt_fraction_bit_pattern_search_top
// square root fraction bit pattern search with an iterative root datapath
// ----------------------------------------------------------------------------
// done follows the last of the ROOT_W = 138 root steps; no new start is taken
// before done is strobed, and the single root subtractor resolves one root
//   bit per cycle (10 integer + 128 fraction)
// busy is high from the accepted start until the cycle done is strobed
// reset: synchronous, active high; clears the sequencer and the strobe
// results are strobed for one cycle and the receiver cannot stall them
// ----------------------------------------------------------------------------
module sqrt_fraction_bit_pattern_search_top
  import sqfps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [RAD_W-1:0] radicand,
  input  logic [PAT_W-1:0] pattern_bits,
  input  logic [LEN_W-1:0] pattern_length,
  output logic             done,
  output logic             found,
  output logic [POS_W-1:0] position
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [RAD_W-1:0]  rad;
  seq_ctl_t          ctl;
  logic              accept;
  logic              last_step;
  logic [1:0]        pair;
  logic              root_bit;
  match_res_t        res;

  // a transaction is taken when start meets a block that is not busy
  assign accept    = start && !busy;
  assign busy      = (state == ST_RUN);
  assign last_step = (step == STEP_W'(ROOT_W - 1));

  always_comb begin
    ctl.init = accept;
    ctl.step = (state == ST_RUN);
    ctl.frac = (step >= STEP_W'(INT_PAIRS));
    // radicand pairs feed the integer steps, zeros follow
    pair     = ctl.frac ? 2'b00 : rad[RAD_W-1:RAD_W-2];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_step) state_next = ST_DONE;
      end
      ST_DONE: begin
        // back to back start is accepted while done is strobed
        state_next = accept ? ST_RUN : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (state == ST_RUN) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // radicand shifts out two bits per root step
  always_ff @(posedge clk) begin
    if (accept) begin
      rad <= radicand;
    end else if (ctl.step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
    end
  end

  sqfps_root_unit u_root (
    .clk      (clk),
    .ctl      (ctl),
    .pair     (pair),
    .root_bit (root_bit)
  );

  sqfps_match u_match (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .frac_bit       (root_bit),
    .pattern_bits   (pattern_bits),
    .pattern_length (pattern_length),
    .res            (res)
  );

  // the result stays in the matcher until the next start, so the strobe
  // can simply mark the cycle after the last root step
  assign done     = (state == ST_DONE);
  assign found    = res.found;
  assign position = res.position;

endmodule
